// ===== rtl/mvm_pkg.sv =====
package mvm_pkg;

   localparam int MAX_DIM   = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 4;
   localparam int DIM_W     = 5;
   localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(MAT_DEPTH);
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 2;
   localparam int FRAC_W    = 16;

   localparam logic [2:0] CMD_WRITE_MAT = 3'd0;
   localparam logic [2:0] CMD_FILL_IDENT = 3'd1;
   localparam logic [2:0] CMD_WRITE_VEC = 3'd2;
   localparam logic [2:0] CMD_READ = 3'd3;
   localparam logic [2:0] CMD_MULTIPLY = 3'd4;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mvm_tag_type;

   typedef struct packed {
      logic                     valid;
      logic                     saturated;
      logic signed [DATA_W-1:0] value;
   } mvm_result_type;

endpackage

// ===== rtl/matrix_vector_multiply_core.sv =====
// Channel  | Direction | Ports                                             | Handshake
// req      | in        | req_command, req_row, req_column, req_value       | req_valid / req_stall
// rsp      | out       | rsp_result_index, rsp_result_value, rsp_saturated,| rsp_valid / rsp_stall
//          |           | rsp_last                                          |
// csr      | in        | csr_write_data (dimension)                        | csr_write_enable
//
// Element and vector writes end at the accept; a read uses the RAM read register, then output wait.
// Identity fill sweeps the 256-entry matrix memory, one entry per cycle.
// Multiply streams one element per cycle within a row, then waits for the row result and a free
// rsp word; it uses the single multiply-accumulate unit fed by the matrix and vector memories.
// Synchronous active-high reset; memories are not cleared, dimension resets to 16.
// A stalled rsp word holds; req is stalled while a command is in progress.
module matrix_vector_multiply_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [2:0]                            req_command,
   input  logic [mvm_pkg::IDX_W-1:0]             req_row,
   input  logic [mvm_pkg::IDX_W-1:0]             req_column,
   input  logic signed [mvm_pkg::DATA_W-1:0]     req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mvm_pkg::IDX_W-1:0]             rsp_result_index,
   output logic signed [mvm_pkg::DATA_W-1:0]     rsp_result_value,
   output logic                                  rsp_saturated,
   output logic                                  rsp_last,
   input  logic                                  csr_write_enable,
   input  logic [mvm_pkg::DIM_W-1:0]             csr_write_data
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FILL     = 3'd1;
   localparam logic [2:0] ST_READ     = 3'd2;
   localparam logic [2:0] ST_MUL_RUN  = 3'd3;
   localparam logic [2:0] ST_MUL_WAIT = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [mvm_pkg::DIM_W-1:0]         dim_ff, size;
   logic [mvm_pkg::IDX_W-1:0]         row_ff, row_in, col_ff, col_in;
   logic [mvm_pkg::ADDR_W-1:0]        fill_ff, fill_in;
   logic signed [mvm_pkg::DATA_W-1:0] fill_value_ff;
   logic                              rd_range_ff;
   logic                              accept, in_range, col_last, row_last, out_free;

   logic                              mat_we, mat_re, vec_we, vec_re;
   logic [mvm_pkg::ADDR_W-1:0]        mat_waddr, mat_raddr;
   logic [mvm_pkg::DATA_W-1:0]        mat_wdata, mat_rdata, vec_rdata;
   mvm_pkg::mvm_tag_type              tag;
   mvm_pkg::mvm_result_type           mac_result;
   logic                              take;

   logic                              rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [mvm_pkg::IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic signed [mvm_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                              rsp_sat_ff, rsp_sat_in, rsp_last_ff, rsp_last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM);
      end else if (csr_write_enable) begin
         dim_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (dim_ff == '0) begin
         size = mvm_pkg::DIM_W'(1);
      end else if (dim_ff > mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM)) begin
         size = mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM);
      end else begin
         size = dim_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign in_range  = ({1'b0, req_row} < size) && ({1'b0, req_column} < size);
   assign col_last  = ({1'b0, col_ff} + mvm_pkg::DIM_W'(1)) == size;
   assign row_last  = ({1'b0, row_ff} + mvm_pkg::DIM_W'(1)) == size;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // memory port steering
   always_comb begin
      mat_we    = 1'b0;
      mat_waddr = {req_row, req_column};
      mat_wdata = req_value;
      if (state_ff == ST_FILL) begin
         mat_we    = 1'b1;
         mat_waddr = fill_ff;
         mat_wdata = (fill_ff[mvm_pkg::ADDR_W-1:mvm_pkg::IDX_W] ==
                      fill_ff[mvm_pkg::IDX_W-1:0]) ? fill_value_ff : '0;
      end else if (accept && req_command == mvm_pkg::CMD_WRITE_MAT && in_range) begin
         mat_we = 1'b1;
      end
   end

   assign mat_re    = (state_ff == ST_MUL_RUN) || (accept && req_command == mvm_pkg::CMD_READ);
   assign mat_raddr = (state_ff == ST_MUL_RUN) ? {row_ff, col_ff} : {req_row, req_column};
   assign vec_we    = accept && req_command == mvm_pkg::CMD_WRITE_VEC
                      && ({1'b0, req_column} < size);
   assign vec_re    = (state_ff == ST_MUL_RUN);

   assign tag.valid = (state_ff == ST_MUL_RUN);
   assign tag.first = (col_ff == '0);
   assign tag.last  = col_last;

   mvm_ram #(
      .DEPTH (mvm_pkg::MAT_DEPTH),
      .WIDTH (mvm_pkg::DATA_W)
   ) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_en   (mat_re),
      .rd_addr (mat_raddr),
      .rd_data (mat_rdata)
   );

   mvm_ram #(
      .DEPTH (mvm_pkg::MAX_DIM),
      .WIDTH (mvm_pkg::DATA_W)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (req_column),
      .wr_data (req_value),
      .rd_en   (vec_re),
      .rd_addr (col_ff),
      .rd_data (vec_rdata)
   );

   mvm_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag),
      .mat_data (mat_rdata),
      .vec_data (vec_rdata),
      .take     (take),
      .result   (mac_result)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      fill_in      = fill_ff;
      take         = 1'b0;
      rsp_load     = 1'b0;
      rsp_index_in = row_ff;
      rsp_value_in = mac_result.value;
      rsp_sat_in   = mac_result.saturated;
      rsp_last_in  = row_last;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  mvm_pkg::CMD_FILL_IDENT: begin
                     fill_in  = '0;
                     state_in = ST_FILL;
                  end
                  mvm_pkg::CMD_READ: begin
                     row_in   = req_row;
                     state_in = ST_READ;
                  end
                  mvm_pkg::CMD_MULTIPLY: begin
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_MUL_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            fill_in = fill_ff + mvm_pkg::ADDR_W'(1);
            if (&fill_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_value_in = rd_range_ff ? mat_rdata : '0;
            rsp_sat_in   = 1'b0;
            rsp_last_in  = 1'b1;
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL_RUN: begin
            col_in = col_ff + mvm_pkg::IDX_W'(1);
            if (col_last) begin
               state_in = ST_MUL_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mac_result.valid && out_free) begin
               rsp_load = 1'b1;
               take     = 1'b1;
               col_in   = '0;
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + mvm_pkg::IDX_W'(1);
                  state_in = ST_MUL_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fill_value_ff <= req_value;
         rd_range_ff   <= in_range;
      end
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= rsp_index_in;
         rsp_value_ff <= rsp_value_in;
         rsp_sat_ff   <= rsp_sat_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   a_mac_result_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_result.valid |-> state_ff == ST_MUL_WAIT)
      else $error("mac result pending outside multiply wait");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_RUN || state_ff == ST_MUL_WAIT) |-> ({1'b0, row_ff} < size))
      else $error("multiply row beyond size in use");

   a_fill_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      (mat_we && state_ff != ST_IDLE) |-> state_ff == ST_FILL)
      else $error("matrix write outside fill or idle");
`endif

endmodule

// ===== rtl/mvm_ram.sv =====
module mvm_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mvm_mac.sv =====
module mvm_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mvm_pkg::mvm_tag_type                   tag,
   input  logic signed [mvm_pkg::DATA_W-1:0]      mat_data,
   input  logic signed [mvm_pkg::DATA_W-1:0]      vec_data,
   input  logic                                   take,
   output mvm_pkg::mvm_result_type                result
);

   localparam int SH_W = mvm_pkg::ACC_W - mvm_pkg::FRAC_W;

   mvm_pkg::mvm_tag_type tag1_ff, tag2_ff, tag3_ff;
   logic signed [mvm_pkg::PROD_W-1:0] prod_ff;
   logic signed [mvm_pkg::ACC_W-1:0]  acc_ff, acc_in, rnd;
   logic [SH_W-1:0]                   sh;
   logic                              fits, neg;
   logic                              res_valid_ff, res_sat_ff, res_sat_in;
   logic signed [mvm_pkg::DATA_W-1:0] res_value_ff, res_value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag1_ff.valid) begin
         prod_ff <= mat_data * vec_data;
      end
   end

   assign acc_in = (tag2_ff.first ? '0 : acc_ff)
                 + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_ff[mvm_pkg::PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // round to nearest, ties up, then clip to 32 bits
   assign rnd  = acc_ff + {{(mvm_pkg::ACC_W - mvm_pkg::FRAC_W){1'b0}}, 16'h8000};
   assign sh   = rnd[mvm_pkg::ACC_W-1:mvm_pkg::FRAC_W];
   assign neg  = sh[SH_W-1];
   assign fits = (&sh[SH_W-1:mvm_pkg::DATA_W-1]) || !(|sh[SH_W-1:mvm_pkg::DATA_W-1]);

   always_comb begin
      if (fits) begin
         res_value_in = sh[mvm_pkg::DATA_W-1:0];
         res_sat_in   = 1'b0;
      end else begin
         res_value_in = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         res_sat_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (tag3_ff.valid && tag3_ff.last) begin
         res_valid_ff <= 1'b1;
      end else if (take) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tag3_ff.valid && tag3_ff.last) begin
         res_value_ff <= res_value_in;
         res_sat_ff   <= res_sat_in;
      end
   end

   assign result.valid     = res_valid_ff;
   assign result.saturated = res_sat_ff;
   assign result.value     = res_value_ff;

endmodule

// ===== dv/tb_matrix_vector_multiply_core.sv =====
module tb_matrix_vector_multiply_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
   localparam int QUIET_CYCLES = 400;
   localparam int WORDS_PER_PHASE = 24;

   typedef struct {
      logic [mvm_pkg::IDX_W-1:0]  index;
      logic [mvm_pkg::DATA_W-1:0] value;
      logic                       saturated;
      logic                       last;
   } answer_type;

   class matvec_tracker;
      logic [mvm_pkg::DATA_W-1:0] matrix [mvm_pkg::MAT_DEPTH];
      logic [mvm_pkg::DATA_W-1:0] vector [mvm_pkg::MAX_DIM];
      bit                         matrix_set [mvm_pkg::MAT_DEPTH];
      bit                         vector_set [mvm_pkg::MAX_DIM];
      logic [mvm_pkg::DIM_W-1:0]  dim_reg;
      answer_type                 answers_due [$];
      int                         errors;

      function new();
         dim_reg = 5'd16;
         errors  = 0;
         foreach (matrix[i]) begin
            matrix[i]     = '0;
            matrix_set[i] = 1'b0;
         end
         foreach (vector[i]) begin
            vector[i]     = '0;
            vector_set[i] = 1'b0;
         end
      endfunction

      function int size_now();
         int d;
         d = dim_reg;
         if (d < 1) d = 1;
         if (d > mvm_pkg::MAX_DIM) d = mvm_pkg::MAX_DIM;
         if (d > 16) d = 16;
         return d;
      endfunction

      function void set_dimension(logic [mvm_pkg::DIM_W-1:0] d);
         dim_reg = d;
      endfunction

      function int due();
         return answers_due.size();
      endfunction

      function bit missing_operand(int n, output logic [2:0] cmd,
                                   output logic [mvm_pkg::IDX_W-1:0] r,
                                   output logic [mvm_pkg::IDX_W-1:0] c);
         cmd = mvm_pkg::CMD_WRITE_VEC;
         r   = '0;
         c   = '0;
         for (int j = 0; j < n; j++) begin
            if (!vector_set[j]) begin
               c = 4'(j);
               return 1'b1;
            end
         end
         cmd = mvm_pkg::CMD_WRITE_MAT;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               if (!matrix_set[i * mvm_pkg::MAX_DIM + j]) begin
                  r = 4'(i);
                  c = 4'(j);
                  return 1'b1;
               end
            end
         end
         return 1'b0;
      endfunction

      function void dot_product(int r, int n, output logic [mvm_pkg::DATA_W-1:0] val,
                                output logic sat);
         logic signed [79:0] acc;
         logic signed [63:0] prod;
         acc = '0;
         for (int j = 0; j < n; j++) begin
            prod = $signed(matrix[r * mvm_pkg::MAX_DIM + j]) * $signed(vector[j]);
            acc  = acc + prod;
         end
         acc = (acc + 80'sd32768) >>> 16;
         if (acc > 80'sh7FFF_FFFF) begin
            val = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if (acc < -80'sh8000_0000) begin
            val = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            val = acc[31:0];
            sat = 1'b0;
         end
      endfunction

      function void note_command(logic [2:0] cmd, logic [mvm_pkg::IDX_W-1:0] r,
                                 logic [mvm_pkg::IDX_W-1:0] c,
                                 logic [mvm_pkg::DATA_W-1:0] v);
         answer_type a;
         int         n;
         int         ri;
         int         ci;
         n  = size_now();
         ri = int'(r);
         ci = int'(c);
         case (cmd)
            mvm_pkg::CMD_WRITE_MAT: begin
               if (ri < n && ci < n) begin
                  matrix[ri * mvm_pkg::MAX_DIM + ci]     = v;
                  matrix_set[ri * mvm_pkg::MAX_DIM + ci] = 1'b1;
               end
            end
            mvm_pkg::CMD_FILL_IDENT: begin
               for (int i = 0; i < mvm_pkg::MAT_DEPTH; i++) begin
                  matrix[i] = (i / mvm_pkg::MAX_DIM == i % mvm_pkg::MAX_DIM) ? v : '0;
                  matrix_set[i] = 1'b1;
               end
            end
            mvm_pkg::CMD_WRITE_VEC: begin
               if (ci < n) begin
                  vector[ci]     = v;
                  vector_set[ci] = 1'b1;
               end
            end
            mvm_pkg::CMD_READ: begin
               a.index     = r;
               a.value     = (ri < n && ci < n) ? matrix[ri * mvm_pkg::MAX_DIM + ci] : '0;
               a.saturated = 1'b0;
               a.last      = 1'b1;
               answers_due.push_back(a);
            end
            mvm_pkg::CMD_MULTIPLY: begin
               for (int i = 0; i < n; i++) begin
                  dot_product(i, n, a.value, a.saturated);
                  a.index = 4'(i);
                  a.last  = (i == n - 1);
                  answers_due.push_back(a);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [mvm_pkg::IDX_W-1:0] index,
                                 logic [mvm_pkg::DATA_W-1:0] value,
                                 logic saturated, logic last);
         answer_type want;
         if (answers_due.size() == 0) begin
            $error("result word with none expected: result_index %0d result_value %h",
                   index, value);
            errors++;
            return;
         end
         want = answers_due.pop_front();
         if (index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, index);
            errors++;
         end
         if (value !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, value);
            errors++;
         end
         if (saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, saturated);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [2:0]                        req_command = '0;
   logic [mvm_pkg::IDX_W-1:0]         req_row = '0;
   logic [mvm_pkg::IDX_W-1:0]         req_column = '0;
   logic signed [mvm_pkg::DATA_W-1:0] req_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [mvm_pkg::IDX_W-1:0]         rsp_result_index;
   logic signed [mvm_pkg::DATA_W-1:0] rsp_result_value;
   logic                              rsp_saturated;
   logic                              rsp_last;
   logic                              csr_write_enable = 1'b0;
   logic [mvm_pkg::DIM_W-1:0]         csr_write_data = '0;

   bit                                no_idle = 1'b0;
   logic [mvm_pkg::DIM_W-1:0]         dim_plan [0:8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3,
                                                         5'd17, 5'd7, 5'd2, 5'd16};
   matvec_tracker                     tracker;

   matrix_vector_multiply_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_row          (req_row),
      .req_column       (req_column),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #8ms;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [mvm_pkg::IDX_W-1:0] pick_index(int n);
      if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, n - 1));
   endfunction

   function automatic logic [mvm_pkg::DATA_W-1:0] pick_value();
      logic [mvm_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = '0;
         3, 4: v = $urandom();
         default: begin
            v = $urandom_range(0, 32'h0010_0000);
            v = v - 32'h0008_0000;
         end
      endcase
      return v;
   endfunction

   task automatic send_word(input logic [2:0] cmd, input logic [mvm_pkg::IDX_W-1:0] r,
                            input logic [mvm_pkg::IDX_W-1:0] c,
                            input logic [mvm_pkg::DATA_W-1:0] v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_row     <= r;
      req_column  <= c;
      req_value   <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_command(cmd, r, c, v);
      @(negedge clock);
   endtask

   task automatic wait_drained(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.due() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_dimension(input logic [mvm_pkg::DIM_W-1:0] d);
      csr_write_data   <= d;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_dimension(d);
   endtask

   task automatic send_random_word(inout int counted);
      int                         sel;
      int                         n;
      logic [2:0]                 cmd;
      logic [2:0]                 fix_cmd;
      logic [mvm_pkg::IDX_W-1:0]  r;
      logic [mvm_pkg::IDX_W-1:0]  c;
      logic [mvm_pkg::IDX_W-1:0]  fix_r;
      logic [mvm_pkg::IDX_W-1:0]  fix_c;
      logic [mvm_pkg::DATA_W-1:0] v;
      n   = tracker.size_now();
      sel = $urandom_range(0, 99);
      r   = pick_index(n);
      c   = pick_index(n);
      v   = pick_value();
      if (sel < 28) cmd = mvm_pkg::CMD_WRITE_MAT;
      else if (sel < 33) cmd = mvm_pkg::CMD_FILL_IDENT;
      else if (sel < 55) cmd = mvm_pkg::CMD_WRITE_VEC;
      else if (sel < 72) cmd = mvm_pkg::CMD_READ;
      else if (sel < 95) cmd = mvm_pkg::CMD_MULTIPLY;
      else cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      // never read an entry that holds nothing yet: write it instead
      if (cmd == mvm_pkg::CMD_READ && int'(r) < n && int'(c) < n
          && !tracker.matrix_set[int'(r) * mvm_pkg::MAX_DIM + int'(c)])
         cmd = mvm_pkg::CMD_WRITE_MAT;
      if (cmd == mvm_pkg::CMD_MULTIPLY
          && tracker.missing_operand(n, fix_cmd, fix_r, fix_c)) begin
         cmd = fix_cmd;
         r   = fix_r;
         c   = fix_c;
      end
      send_word(cmd, r, c, v);
      if (cmd >= CMD_UNUSED_LO) return;
      if (cmd == mvm_pkg::CMD_WRITE_MAT && (int'(r) >= n || int'(c) >= n)) return;
      if (cmd == mvm_pkg::CMD_WRITE_VEC && int'(c) >= n) return;
      counted++;
   endtask

   initial begin : rsp_side
      int hold;
      @(negedge reset);
      @(negedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.check_result(rsp_result_index, rsp_result_value, rsp_saturated, rsp_last);
         @(negedge clock);
      end
   end

   initial begin : req_side
      int counted;
      tracker = new();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_dimension(5'd2);
      send_word(mvm_pkg::CMD_FILL_IDENT, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_word(mvm_pkg::CMD_WRITE_VEC, 4'd0, 4'd0, 32'h7FFF_FFFF);
      send_word(mvm_pkg::CMD_WRITE_VEC, 4'd0, 4'd1, 32'h8000_0000);
      send_word(mvm_pkg::CMD_MULTIPLY, 4'd0, 4'd0, 32'h0);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd0, 4'd1, 32'h8000_0000);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd1, 4'd0, 32'hFFFF_0000);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd2, 4'd0, 32'h1234_5678);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd0, 4'd15, 32'hFFFF_FFFF);
      send_word(mvm_pkg::CMD_WRITE_VEC, 4'd0, 4'd15, 32'h0000_0001);
      send_word(mvm_pkg::CMD_READ, 4'd0, 4'd1, 32'h0);
      send_word(mvm_pkg::CMD_READ, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_word(mvm_pkg::CMD_READ, 4'd1, 4'd3, 32'h0);
      send_word(mvm_pkg::CMD_MULTIPLY, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_word(CMD_UNUSED_LO, 4'd0, 4'd0, 32'h0001_0000);
      send_word(CMD_UNUSED_LO + 3'd1, 4'd1, 4'd1, 32'h0);
      send_word(CMD_UNUSED_HI, 4'd15, 4'd15, 32'hFFFF_FFFF);
      send_word(mvm_pkg::CMD_FILL_IDENT, 4'd0, 4'd0, 32'h0);
      send_word(mvm_pkg::CMD_MULTIPLY, 4'd0, 4'd0, 32'h0);
      // round half a unit up and minus half a unit toward zero
      send_word(mvm_pkg::CMD_FILL_IDENT, 4'd0, 4'd0, 32'h0001_0000);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd0, 4'd0, 32'h0000_8000);
      send_word(mvm_pkg::CMD_WRITE_MAT, 4'd1, 4'd1, 32'hFFFF_8000);
      send_word(mvm_pkg::CMD_WRITE_VEC, 4'd0, 4'd0, 32'h0000_0001);
      send_word(mvm_pkg::CMD_WRITE_VEC, 4'd0, 4'd1, 32'h0000_0001);
      send_word(mvm_pkg::CMD_MULTIPLY, 4'd0, 4'd0, 32'h0);
      send_word(mvm_pkg::CMD_READ, 4'd1, 4'd1, 32'h0);

      for (int p = 0; p < 9; p++) begin
         wait_drained(QUIET_CYCLES);
         write_dimension(dim_plan[p]);
         no_idle = (p % 3 == 2);
         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 24) == 0) wait_drained(0);
            send_random_word(counted);
         end
      end

      wait_drained(QUIET_CYCLES);
      if (tracker.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
